// ----- design/tmp_pkg.sv -----
`default_nettype none
package tmp_pkg;

	localparam int TICK_SHIFT  = 4;
	localparam int COUNT_WIDTH = 12;

	localparam int SPEED_W = 16;
	localparam int POS_W   = 32;
	localparam int TICKS_W = 12;

	localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(256);
	localparam logic [SPEED_W-1:0] SPEED_MAX_RESET = SPEED_W'(5120);
	localparam logic [SPEED_W-1:0] RATE_RESET = SPEED_W'(512);

	// command codes on the input tuser
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	// profile phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ACCEL  = 2'd1;
	localparam logic [1:0] PH_CRUISE = 2'd2;
	localparam logic [1:0] PH_DECEL  = 2'd3;

	// configuration register indexes
	localparam logic REG_MAX_SPEED  = 1'b0;
	localparam logic REG_ACCEL_RATE = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 56;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// one decoded item as it waits in the queue
	typedef struct packed {
		logic              is_tick;
		logic              is_start;
		logic              is_load;
		logic              is_stop;
		count_t            accel_ticks;
		count_t            cruise_ticks;
		count_t            decel_ticks;
		logic              direction_up;
		logic [POS_W-1:0]  position_value;
	} item_t;

	// position step for one tick at a given speed
	function automatic logic [POS_W-1:0] pos_delta(input logic [SPEED_W-1:0] speed);
		logic [POS_W-1:0] wide;
		wide = POS_W'(speed);
		if (TICK_SHIFT <= 4)
			return wide << (4 - TICK_SHIFT);
		else
			return wide >> (TICK_SHIFT - 4);
	endfunction

endpackage
`default_nettype wire

// ----- design/trapezoidal_motion_profile_unit.sv -----
// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    command (tuser), move and position fields
// m_axis    out        m_axis_tvalid/tready    speed, position, phase, done, adjust
// config    in         wr_en                   wr_index, wr_data
//
// One result per item; an item can be taken every cycle while the queue is not full.
// Its result passes through the queue, then the output register.
// The profile state update is a single registered step per item in the back end.
// A four-entry queue lets input keep flowing while the output is stalled.
// Reset is asynchronous: phase idle, speed and position zero, registers to defaults.
`default_nettype none
module trapezoidal_motion_profile_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// accel_ticks[11:0], cruise_ticks[23:12], decel_ticks[35:24],
	// direction_up[36], position_value[68:37], zero[71:69]
	input  wire logic [tmp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// command[1:0]
	input  wire logic [1:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// speed_now[15:0], position_now[47:16], phase_now[49:48],
	// move_done[50], adjust_flag[51], zero[55:52]
	output logic [tmp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  wire logic                            wr_en,
	input  wire logic                            wr_index,
	input  wire logic [15:0]                     wr_data
);

	tmp_pkg::item_t push_item;
	tmp_pkg::item_t head_item;
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;

	tmp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	tmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_item (head_item)
	);

	tmp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- design/tmp_front.sv -----
`default_nettype none
module tmp_front (
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [tmp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  wire logic [1:0]                      s_axis_tuser,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output tmp_pkg::item_t                       q_item
);

	logic [1:0] cmd;

	assign cmd           = s_axis_tuser;
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_item = '0;
		unique case (cmd)
			tmp_pkg::CMD_TICK:  q_item.is_tick  = 1'b1;
			tmp_pkg::CMD_START: q_item.is_start = 1'b1;
			tmp_pkg::CMD_LOAD:  q_item.is_load  = 1'b1;
			tmp_pkg::CMD_STOP:  q_item.is_stop  = 1'b1;
			default:            q_item.is_tick  = 1'b1;
		endcase
		// counts are taken modulo the counter width
		q_item.accel_ticks    = tmp_pkg::count_t'(s_axis_tdata[11:0]);
		q_item.cruise_ticks   = tmp_pkg::count_t'(s_axis_tdata[23:12]);
		q_item.decel_ticks    = tmp_pkg::count_t'(s_axis_tdata[35:24]);
		q_item.direction_up   = s_axis_tdata[36];
		q_item.position_value = s_axis_tdata[68:37];
	end

endmodule
`default_nettype wire

// ----- design/tmp_queue.sv -----
`default_nettype none
module tmp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  tmp_pkg::item_t       push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output tmp_pkg::item_t       head_item
);

	tmp_pkg::item_t                  entry_q [tmp_pkg::QUEUE_DEPTH];
	logic [tmp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tmp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tmp_pkg::QPTR_W:0]        count_q;

	assign full      = (count_q == (tmp_pkg::QPTR_W+1)'(tmp_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- design/tmp_back.sv -----
`default_nettype none
module tmp_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic                            wr_index,
	input  wire logic [15:0]                     wr_data,
	input  wire logic                            q_valid,
	input  tmp_pkg::item_t                       q_item,
	output logic                                 q_pop,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [tmp_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

	logic [tmp_pkg::SPEED_W-1:0] max_speed_q;
	logic [tmp_pkg::SPEED_W-1:0] accel_rate_q;

	logic [1:0]                  phase_q;
	tmp_pkg::count_t             left_q;
	logic [tmp_pkg::SPEED_W-1:0] speed_q;
	logic [tmp_pkg::POS_W-1:0]   pos_q;
	logic                        up_q;
	tmp_pkg::count_t             cruise_q;
	tmp_pkg::count_t             decel_q;

	logic                        out_valid_q;
	logic [tmp_pkg::SPEED_W-1:0] out_speed_q;
	logic [tmp_pkg::POS_W-1:0]   out_pos_q;
	logic [1:0]                  out_phase_q;
	logic                        out_done_q;
	logic                        out_adj_q;

	logic [1:0]                  n_phase;
	tmp_pkg::count_t             n_left;
	logic [tmp_pkg::SPEED_W-1:0] n_speed;
	logic [tmp_pkg::POS_W-1:0]   n_pos;
	logic                        n_up;
	tmp_pkg::count_t             n_cruise;
	tmp_pkg::count_t             n_decel;
	logic                        adj;
	logic                        done;
	logic                        enter_cruise;
	logic                        enter_decel;
	logic [tmp_pkg::SPEED_W-1:0] rate;
	logic [tmp_pkg::SPEED_W-1:0] inc;
	logic [tmp_pkg::SPEED_W:0]   sum;
	tmp_pkg::count_t             left_dec;

	// take the next item whenever the output slot is free or being drained
	assign q_pop         = q_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_adj_q, out_done_q, out_phase_q, out_pos_q, out_speed_q};

	always_comb begin
		n_phase      = phase_q;
		n_left       = left_q;
		n_speed      = speed_q;
		n_pos        = pos_q;
		n_up         = up_q;
		n_cruise     = cruise_q;
		n_decel      = decel_q;
		adj          = 1'b0;
		done         = 1'b0;
		enter_cruise = 1'b0;
		enter_decel  = 1'b0;
		rate         = (accel_rate_q < max_speed_q) ? accel_rate_q : max_speed_q;
		inc          = rate >> tmp_pkg::TICK_SHIFT;
		sum          = {1'b0, speed_q} + {1'b0, inc};
		left_dec     = left_q - 1'b1;

		priority if (q_item.is_start) begin
			if (phase_q == tmp_pkg::PH_IDLE) begin
				n_cruise = q_item.cruise_ticks;
				n_decel  = q_item.decel_ticks;
				n_up     = q_item.direction_up;
				n_speed  = '0;
				if (q_item.accel_ticks != '0) begin
					n_phase = tmp_pkg::PH_ACCEL;
					n_left  = q_item.accel_ticks;
				end else begin
					enter_cruise = 1'b1;
				end
			end
		end else if (q_item.is_load) begin
			n_pos = q_item.position_value;
		end else if (q_item.is_stop) begin
			n_phase = tmp_pkg::PH_IDLE;
			n_left  = '0;
			n_speed = '0;
			done    = 1'b1;
		end else if (q_item.is_tick && phase_q != tmp_pkg::PH_IDLE) begin
			unique case (phase_q)
				tmp_pkg::PH_ACCEL: begin
					if (speed_q < max_speed_q)
						n_speed = sum[tmp_pkg::SPEED_W] ? '1 : sum[tmp_pkg::SPEED_W-1:0];
					else begin
						n_speed = max_speed_q;
						adj     = 1'b1;
					end
					n_pos = up_q ? pos_q + tmp_pkg::pos_delta(n_speed)
					             : pos_q - tmp_pkg::pos_delta(n_speed);
				end
				tmp_pkg::PH_CRUISE: begin
					n_pos = up_q ? pos_q + tmp_pkg::pos_delta(speed_q)
					             : pos_q - tmp_pkg::pos_delta(speed_q);
				end
				default: begin
					if (speed_q > rate && speed_q > tmp_pkg::SPEED_ONE) begin
						n_speed = speed_q - inc;
						n_pos   = up_q ? pos_q + tmp_pkg::pos_delta(n_speed)
						               : pos_q - tmp_pkg::pos_delta(n_speed);
					end else begin
						n_speed = '0;
						adj     = 1'b1;
					end
				end
			endcase
			n_left = left_dec;
			if (left_dec == '0) begin
				unique case (phase_q)
					tmp_pkg::PH_ACCEL:  enter_cruise = 1'b1;
					tmp_pkg::PH_CRUISE: enter_decel  = 1'b1;
					default: begin
						n_phase = tmp_pkg::PH_IDLE;
						n_speed = '0;
						done    = 1'b1;
					end
				endcase
			end
		end else begin
			// tick while idle: hold the profile
		end

		// skip phases with zero ticks
		if (enter_cruise) begin
			if (n_cruise != '0) begin
				n_phase = tmp_pkg::PH_CRUISE;
				n_left  = n_cruise;
				if (n_speed != max_speed_q) begin
					n_speed = max_speed_q;
					adj     = 1'b1;
				end
			end else begin
				enter_decel = 1'b1;
			end
		end
		if (enter_decel) begin
			if (n_decel != '0) begin
				n_phase = tmp_pkg::PH_DECEL;
				n_left  = n_decel;
			end else begin
				n_phase = tmp_pkg::PH_IDLE;
				n_left  = '0;
				n_speed = '0;
				done    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= tmp_pkg::SPEED_MAX_RESET;
			accel_rate_q <= tmp_pkg::RATE_RESET;
			phase_q      <= tmp_pkg::PH_IDLE;
			left_q       <= '0;
			speed_q      <= '0;
			pos_q        <= '0;
			up_q         <= 1'b0;
			cruise_q     <= '0;
			decel_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					tmp_pkg::REG_MAX_SPEED:  max_speed_q  <= wr_data;
					tmp_pkg::REG_ACCEL_RATE: accel_rate_q <= wr_data;
					default: ;
				endcase
			end
			if (q_pop) begin
				phase_q     <= n_phase;
				left_q      <= n_left;
				speed_q     <= n_speed;
				pos_q       <= n_pos;
				up_q        <= n_up;
				cruise_q    <= n_cruise;
				decel_q     <= n_decel;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_speed_q <= n_speed;
			out_pos_q   <= n_pos;
			out_phase_q <= n_phase;
			out_done_q  <= done;
			out_adj_q   <= adj;
		end
	end

endmodule
`default_nettype wire
